FILE: rtl/pcl_pkg.sv
`timescale 1ns / 1ps

package pcl_pkg;

    // Table geometry and field widths
    localparam int NUM_SLOTS = 1024;
    localparam int IDX_W     = 10;
    localparam int LBL_W     = 11;
    localparam int CNT_W     = 11;
    localparam int OFF_W     = 8;
    localparam int IMG_W     = 3 * OFF_W;
    localparam int ACT_W     = 3;
    localparam int CMD_W     = 2;

    localparam logic [LBL_W-1:0] NO_LABEL   = '1;
    localparam logic [CNT_W-1:0] SLOT_COUNT = CNT_W'(NUM_SLOTS);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PAIR    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLOSE   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_NEW    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_JOIN_A = 3'd2;
    localparam logic [ACT_W-1:0] ACT_JOIN_B = 3'd3;
    localparam logic [ACT_W-1:0] ACT_MERGE  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_SINGLE = 3'd5;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RDB,
        ST_EVAL,
        ST_WR2,
        ST_SCAN,
        ST_CLEAR,
        ST_DONE
    } state_t;

    // What follows the evaluate step
    typedef enum logic [1:0] {
        EV_DONE,
        EV_WR2,
        EV_SCAN
    } ev_kind_t;

    typedef struct packed {
        logic accept;
        logic init_step;
        logic clear_step;
        logic rd_b;
        logic eval;
        logic wr2;
        logic scan_step;
        logic push;
    } ctl_cmd_t;

    typedef struct packed {
        logic     sweep_done;
        logic     scan_done;
        ev_kind_t ev_kind;
        logic     out_free;
    } dp_status_t;

endpackage

FILE: rtl/pcl_ifs.sv
`timescale 1ns / 1ps

interface pcl_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [9:0]        first_particle;
    logic [9:0]        second_particle;
    logic signed [7:0] offset_x;
    logic signed [7:0] offset_y;
    logic signed [7:0] offset_z;

    modport source (output valid, command, first_particle, second_particle,
                    offset_x, offset_y, offset_z, input ready);
    modport sink   (input valid, command, first_particle, second_particle,
                    offset_x, offset_y, offset_z, output ready);
endinterface

interface pcl_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic signed [10:0] first_label;
    logic signed [10:0] second_label;
    logic [10:0]        moved_count;
    logic [10:0]        clusters_made;
    logic [10:0]        particles_assigned;

    modport source (output valid, action, first_label, second_label, moved_count,
                    clusters_made, particles_assigned, input ready);
    modport sink   (input valid, action, first_label, second_label, moved_count,
                    clusters_made, particles_assigned, output ready);
endinterface

interface pcl_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/pair_cluster_labeler_with_images.sv
// Steps: a pair reads both labels and evaluates, then writes the second slot
// of a new cluster or scans for a merge; a close evaluates; a clear sweeps.
// Throughput: one item at a time; a merge or clear sweeps the label table one
// entry a cycle through its single write port.
// Reset: asynchronous, active low; a pass over all slots then empties all labels
// before the first item is taken (configuration writes are taken throughout).
`timescale 1ns / 1ps

module pair_cluster_labeler_with_images (
    input  logic      clk,
    input  logic      rst_n,
    pcl_in_if.sink    in_ch,
    pcl_out_if.source out_ch,
    pcl_cfg_if.sink   cfg_ch
);
    import pcl_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;
    logic       in_ready;
    logic [10:0] fl, sl;

    assign in_ch.ready  = in_ready;
    assign cfg_ch.ready = 1'b1;

    // Sequencer
    pcl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_cmd   (in_ch.command),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // Tables, counters and result register
    pcl_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .in_command       (in_ch.command),
        .in_first         (in_ch.first_particle),
        .in_second        (in_ch.second_particle),
        .in_off_x         (in_ch.offset_x),
        .in_off_y         (in_ch.offset_y),
        .in_off_z         (in_ch.offset_z),
        .cfg_we           (cfg_ch.valid),
        .cfg_data         (cfg_ch.data),
        .out_valid        (out_ch.valid),
        .out_ready        (out_ch.ready),
        .out_action       (out_ch.action),
        .out_first_label  (fl),
        .out_second_label (sl),
        .out_moved        (out_ch.moved_count),
        .out_clusters     (out_ch.clusters_made),
        .out_assigned     (out_ch.particles_assigned)
    );

    assign out_ch.first_label  = $signed(fl);
    assign out_ch.second_label = $signed(sl);

endmodule

FILE: rtl/pcl_ctrl.sv
`timescale 1ns / 1ps

module pcl_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [1:0]              in_cmd,
    input  pcl_pkg::dp_status_t     status,
    output logic                    in_ready,
    output pcl_pkg::ctl_cmd_t       cmd
);
    import pcl_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_INIT;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (status.sweep_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_cmd)
                        CMD_CLEAR: state_next = ST_CLEAR;
                        CMD_PAIR:  state_next = ST_RDB;
                        CMD_CLOSE: state_next = ST_EVAL;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_RDB:
                state_next = ST_EVAL;
            ST_EVAL:
            begin
                unique case (status.ev_kind)
                    EV_WR2:  state_next = ST_WR2;
                    EV_SCAN: state_next = ST_SCAN;
                    default: state_next = ST_DONE;
                endcase
            end
            ST_WR2:
                state_next = ST_DONE;
            ST_SCAN:
            begin
                if (status.scan_done)
                    state_next = ST_DONE;
            end
            ST_CLEAR:
            begin
                if (status.sweep_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_INIT;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_INIT:  cmd.init_step = 1'b1;
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_RDB:   cmd.rd_b = 1'b1;
            ST_EVAL:  cmd.eval = 1'b1;
            ST_WR2:   cmd.wr2 = 1'b1;
            ST_SCAN:  cmd.scan_step = 1'b1;
            ST_CLEAR: cmd.clear_step = 1'b1;
            ST_DONE:  cmd.push = status.out_free;
            default:  cmd = '0;
        endcase
    end

endmodule

FILE: rtl/pcl_dp.sv
`timescale 1ns / 1ps

module pcl_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pcl_pkg::ctl_cmd_t       cmd,
    output pcl_pkg::dp_status_t     status,
    // input item
    input  logic [1:0]              in_command,
    input  logic [9:0]              in_first,
    input  logic [9:0]              in_second,
    input  logic [7:0]              in_off_x,
    input  logic [7:0]              in_off_y,
    input  logic [7:0]              in_off_z,
    // register write
    input  logic                    cfg_we,
    input  logic [10:0]             cfg_data,
    // result
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [2:0]              out_action,
    output logic [10:0]             out_first_label,
    output logic [10:0]             out_second_label,
    output logic [10:0]             out_moved,
    output logic [10:0]             out_clusters,
    output logic [10:0]             out_assigned
);
    import pcl_pkg::*;

    function automatic logic [IMG_W-1:0] img_add(input logic [IMG_W-1:0] x,
                                                  input logic [IMG_W-1:0] y);
        logic [IMG_W-1:0] r;
        for (int k = 0; k < 3; k++)
            r[k*OFF_W +: OFF_W] = x[k*OFF_W +: OFF_W] + y[k*OFF_W +: OFF_W];
        return r;
    endfunction

    function automatic logic [IMG_W-1:0] img_sub(input logic [IMG_W-1:0] x,
                                                  input logic [IMG_W-1:0] y);
        logic [IMG_W-1:0] r;
        for (int k = 0; k < 3; k++)
            r[k*OFF_W +: OFF_W] = x[k*OFF_W +: OFF_W] - y[k*OFF_W +: OFF_W];
        return r;
    endfunction

    // Label and image tables
    logic [LBL_W-1:0] label_mem [NUM_SLOTS];
    logic [IMG_W-1:0] image_mem [NUM_SLOTS];

    // Control registers
    logic [CNT_W-1:0] piu_reg,      piu_next;
    logic [CNT_W-1:0] idx_reg,      idx_next;
    logic             pend_reg,     pend_next;
    logic [CNT_W-1:0] clusters_reg, clusters_next;
    logic [CNT_W-1:0] assigned_reg, assigned_next;
    logic             ovalid_reg,   ovalid_next;

    // Payload registers
    logic [CMD_W-1:0] cmd_q_reg;
    logic [IDX_W-1:0] a_reg, b_reg, pidx_reg;
    logic [IMG_W-1:0] off_reg, ia_img_reg, mod_reg, ird_reg;
    logic [LBL_W-1:0] la_reg, lb_reg, lrd_reg, fl_reg, sl_reg;
    logic [ACT_W-1:0] act_reg;
    logic [CNT_W-1:0] moved_reg;
    logic [ACT_W-1:0] oact_reg;
    logic [LBL_W-1:0] ofl_reg, osl_reg;
    logic [CNT_W-1:0] omoved_reg, oclus_reg, oasg_reg;

    // Memory ports
    logic [IDX_W-1:0] raddr, waddr;
    logic             we;
    logic [LBL_W-1:0] wlabel;
    logic [IMG_W-1:0] wimg;

    // Evaluate-step decision
    logic [LBL_W-1:0] la, lb;
    logic [IMG_W-1:0] ia_img;
    logic             a_ok, b_ok, full, la_neg, lb_neg;
    ev_kind_t         ev_kind;
    logic [ACT_W-1:0] ev_act;
    logic [LBL_W-1:0] ev_fl, ev_sl;
    logic             ev_we, ev_mk;
    logic [IDX_W-1:0] ev_waddr;
    logic [LBL_W-1:0] ev_wlabel;
    logic [IMG_W-1:0] ev_wimg;
    logic [1:0]       ev_asg;

    logic [CNT_W-1:0] limit;
    logic             idx_lt;
    logic             scan_hit;

    assign limit    = cmd.init_step ? SLOT_COUNT : piu_reg;
    assign idx_lt   = idx_reg < limit;
    assign scan_hit = pend_reg && (lrd_reg == lb_reg);

    assign la     = (cmd_q_reg == CMD_CLOSE) ? lrd_reg : la_reg;
    assign ia_img = (cmd_q_reg == CMD_CLOSE) ? ird_reg : ia_img_reg;
    assign lb     = lrd_reg;
    assign a_ok   = {1'b0, a_reg} < piu_reg;
    assign b_ok   = {1'b0, b_reg} < piu_reg;
    assign full   = clusters_reg >= SLOT_COUNT;
    assign la_neg = la[LBL_W-1];
    assign lb_neg = lb[LBL_W-1];

    // Decision for a pair or close item
    always_comb
    begin
        ev_kind   = EV_DONE;
        ev_act    = ACT_NONE;
        ev_fl     = NO_LABEL;
        ev_sl     = NO_LABEL;
        ev_we     = 1'b0;
        ev_mk     = 1'b0;
        ev_waddr  = a_reg;
        ev_wlabel = clusters_reg;
        ev_wimg   = '0;
        ev_asg    = 2'd0;
        case (cmd_q_reg)
            CMD_PAIR:
            begin
                if (a_ok && b_ok && (a_reg != b_reg))
                begin
                    ev_fl = la;
                    ev_sl = lb;
                    if (la_neg && lb_neg)
                    begin
                        if (!full)
                        begin
                            ev_act  = ACT_NEW;
                            ev_fl   = clusters_reg;
                            ev_sl   = clusters_reg;
                            ev_kind = EV_WR2;
                            ev_we   = 1'b1;
                            ev_mk   = 1'b1;
                            ev_asg  = 2'd2;
                        end
                    end
                    else if (la_neg)
                    begin
                        ev_act    = ACT_JOIN_A;
                        ev_fl     = lb;
                        ev_we     = 1'b1;
                        ev_wlabel = lb;
                        ev_wimg   = img_sub(ird_reg, off_reg);
                        ev_asg    = 2'd1;
                    end
                    else if (lb_neg)
                    begin
                        ev_act    = ACT_JOIN_B;
                        ev_sl     = la;
                        ev_we     = 1'b1;
                        ev_waddr  = b_reg;
                        ev_wlabel = la;
                        ev_wimg   = img_add(ia_img, off_reg);
                        ev_asg    = 2'd1;
                    end
                    else if (la != lb)
                    begin
                        ev_act  = ACT_MERGE;
                        ev_sl   = la;
                        ev_kind = EV_SCAN;
                    end
                end
                else
                begin
                    ev_fl = a_ok ? la : NO_LABEL;
                    ev_sl = b_ok ? lb : NO_LABEL;
                end
            end
            CMD_CLOSE:
            begin
                if (a_ok)
                begin
                    ev_fl = la;
                    if (la_neg && !full)
                    begin
                        ev_act = ACT_SINGLE;
                        ev_fl  = clusters_reg;
                        ev_we  = 1'b1;
                        ev_mk  = 1'b1;
                        ev_asg = 2'd1;
                    end
                end
            end
            default:
                ev_kind = EV_DONE;
        endcase
    end

    // Read address select
    always_comb
    begin
        if (cmd.accept)
            raddr = in_first;
        else if (cmd.rd_b)
            raddr = b_reg;
        else if (cmd.scan_step)
            raddr = idx_reg[IDX_W-1:0];
        else
            raddr = a_reg;
    end

    // Write port select
    always_comb
    begin
        we     = 1'b0;
        waddr  = a_reg;
        wlabel = NO_LABEL;
        wimg   = '0;
        if (cmd.eval)
        begin
            we     = ev_we;
            waddr  = ev_waddr;
            wlabel = ev_wlabel;
            wimg   = ev_wimg;
        end
        else if (cmd.wr2)
        begin
            we     = 1'b1;
            waddr  = b_reg;
            wlabel = fl_reg;
            wimg   = off_reg;
        end
        else if (cmd.scan_step)
        begin
            we     = scan_hit;
            waddr  = pidx_reg;
            wlabel = la_reg;
            wimg   = img_add(ird_reg, mod_reg);
        end
        else if (cmd.init_step || cmd.clear_step)
        begin
            we    = idx_lt;
            waddr = idx_reg[IDX_W-1:0];
        end
    end

    // Tables: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
            label_mem[waddr] <= wlabel;
        lrd_reg <= label_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we && !(cmd.init_step || cmd.clear_step))
            image_mem[waddr] <= wimg;
        ird_reg <= image_mem[raddr];
    end

    // Control next values
    always_comb
    begin
        piu_next      = piu_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        clusters_next = clusters_reg;
        assigned_next = assigned_reg;
        ovalid_next   = ovalid_reg;

        if (cfg_we)
            piu_next = (cfg_data > SLOT_COUNT) ? SLOT_COUNT : cfg_data;

        if (cmd.accept)
        begin
            idx_next  = '0;
            pend_next = 1'b0;
            if (in_command == CMD_CLEAR)
            begin
                clusters_next = '0;
                assigned_next = '0;
            end
        end
        else if (cmd.eval)
        begin
            idx_next      = '0;
            pend_next     = 1'b0;
            clusters_next = clusters_reg + CNT_W'(ev_mk);
            assigned_next = assigned_reg + CNT_W'(ev_asg);
        end
        else if (cmd.scan_step)
        begin
            pend_next = idx_lt;
            if (idx_lt)
                idx_next = idx_reg + 1'b1;
        end
        else if (cmd.init_step || cmd.clear_step)
        begin
            if (idx_lt)
                idx_next = idx_reg + 1'b1;
        end

        if (cmd.push)
            ovalid_next = 1'b1;
        else if (out_ready)
            ovalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            piu_reg      <= SLOT_COUNT;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            clusters_reg <= '0;
            assigned_reg <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            piu_reg      <= piu_next;
            idx_reg      <= idx_next;
            pend_reg     <= pend_next;
            clusters_reg <= clusters_next;
            assigned_reg <= assigned_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    // Item and working payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_q_reg <= in_command;
            a_reg     <= in_first;
            b_reg     <= in_second;
            off_reg   <= {in_off_z, in_off_y, in_off_x};
            act_reg   <= ACT_NONE;
            fl_reg    <= NO_LABEL;
            sl_reg    <= NO_LABEL;
            moved_reg <= '0;
        end
        if (cmd.rd_b)
        begin
            la_reg     <= lrd_reg;
            ia_img_reg <= ird_reg;
        end
        if (cmd.eval)
        begin
            act_reg <= ev_act;
            fl_reg  <= ev_fl;
            sl_reg  <= ev_sl;
            lb_reg  <= lb;
            mod_reg <= img_sub(img_add(ia_img, off_reg), ird_reg);
        end
        if (cmd.scan_step)
        begin
            pidx_reg <= idx_reg[IDX_W-1:0];
            if (scan_hit)
                moved_reg <= moved_reg + 1'b1;
        end
        if (cmd.push)
        begin
            oact_reg   <= act_reg;
            ofl_reg    <= fl_reg;
            osl_reg    <= sl_reg;
            omoved_reg <= moved_reg;
            oclus_reg  <= clusters_reg;
            oasg_reg   <= assigned_reg;
        end
    end

    // Status
    assign status.sweep_done = !idx_lt;
    assign status.scan_done  = !idx_lt && !pend_reg;
    assign status.ev_kind    = ev_kind;
    assign status.out_free   = !ovalid_reg || out_ready;

    assign out_valid        = ovalid_reg;
    assign out_action       = oact_reg;
    assign out_first_label  = ofl_reg;
    assign out_second_label = osl_reg;
    assign out_moved        = omoved_reg;
    assign out_clusters     = oclus_reg;
    assign out_assigned     = oasg_reg;

endmodule

FILE: bench/tb_ifs_note.sv
`timescale 1ns / 1ps

// Shared scoreboard for the pair cluster labeler bench.
package pcl_tb_pkg;
    import pcl_pkg::*;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic signed [LBL_W-1:0] first_label;
        logic signed [LBL_W-1:0] second_label;
        logic [CNT_W-1:0]        moved_count;
        logic [CNT_W-1:0]        clusters_made;
        logic [CNT_W-1:0]        particles_assigned;
    } cluster_result_t;

    class cluster_scoreboard;
        // Mirror of the block's state
        int          slot_label [NUM_SLOTS];
        logic [7:0]  slot_image [NUM_SLOTS][3];
        int          made_count;
        int          placed_count;
        int          slots_in_use;
        cluster_result_t pending[$];
        int          errors;
        int          checked;
        int          merges_seen;
        int          actions_seen [8];

        function new();
            foreach (slot_label[i]) slot_label[i] = -1;
            made_count = 0;
            placed_count = 0;
            slots_in_use = NUM_SLOTS;
            errors = 0;
            checked = 0;
            merges_seen = 0;
        endfunction

        function void set_slots(int value);
            slots_in_use = (value > NUM_SLOTS) ? NUM_SLOTS : value;
        endfunction

        // Work out the result of one accepted transfer and queue it
        function void note_input(logic [1:0] cmd, int a, int b, logic [7:0] ox,
                                 logic [7:0] oy, logic [7:0] oz);
            cluster_result_t r;
            logic [7:0] off [3];
            logic [7:0] shift [3];
            bit a_ok;
            bit b_ok;
            int la;
            int lb;
            int ia;
            int ib;
            int moved;
            logic [2:0] act;
            off[0] = ox;
            off[1] = oy;
            off[2] = oz;
            a_ok = a < slots_in_use;
            b_ok = b < slots_in_use;
            la = -1;
            lb = -1;
            moved = 0;
            act = ACT_NONE;
            if (cmd == CMD_CLEAR)
            begin
                for (int i = 0; i < slots_in_use; i++) slot_label[i] = -1;
                made_count = 0;
                placed_count = 0;
            end
            else if (cmd == CMD_PAIR)
            begin
                if (a_ok && b_ok && a != b)
                begin
                    ia = slot_label[a];
                    ib = slot_label[b];
                    if (ia < 0 && ib < 0)
                    begin
                        if (made_count < NUM_SLOTS)
                        begin
                            for (int k = 0; k < 3; k++)
                            begin
                                slot_image[a][k] = 8'd0;
                                slot_image[b][k] = off[k];
                            end
                            slot_label[a] = made_count;
                            slot_label[b] = made_count;
                            made_count++;
                            placed_count += 2;
                            act = ACT_NEW;
                        end
                    end
                    else if (ia < 0)
                    begin
                        for (int k = 0; k < 3; k++) slot_image[a][k] = slot_image[b][k] - off[k];
                        slot_label[a] = ib;
                        placed_count++;
                        act = ACT_JOIN_A;
                    end
                    else if (ib < 0)
                    begin
                        for (int k = 0; k < 3; k++) slot_image[b][k] = slot_image[a][k] + off[k];
                        slot_label[b] = ia;
                        placed_count++;
                        act = ACT_JOIN_B;
                    end
                    else if (ia != ib)
                    begin
                        for (int k = 0; k < 3; k++)
                            shift[k] = slot_image[a][k] + off[k] - slot_image[b][k];
                        for (int i = 0; i < slots_in_use; i++)
                            if (slot_label[i] == ib)
                            begin
                                for (int k = 0; k < 3; k++)
                                    slot_image[i][k] = slot_image[i][k] + shift[k];
                                slot_label[i] = ia;
                                moved++;
                            end
                        act = ACT_MERGE;
                        merges_seen++;
                    end
                end
                if (a_ok) la = slot_label[a];
                if (b_ok) lb = slot_label[b];
            end
            else if (cmd == CMD_CLOSE)
            begin
                if (a_ok)
                begin
                    if (slot_label[a] < 0 && made_count < NUM_SLOTS)
                    begin
                        for (int k = 0; k < 3; k++) slot_image[a][k] = 8'd0;
                        slot_label[a] = made_count;
                        made_count++;
                        placed_count++;
                        act = ACT_SINGLE;
                    end
                    la = slot_label[a];
                end
            end
            actions_seen[act]++;
            r.action = act;
            r.first_label = LBL_W'(la);
            r.second_label = LBL_W'(lb);
            r.moved_count = CNT_W'(moved);
            r.clusters_made = CNT_W'(made_count);
            r.particles_assigned = CNT_W'(placed_count);
            pending.insert(pending.size(), r);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch on result %0d: %s got %0d expected %0d",
                     checked, what, got, want);
            errors++;
        endtask

        // Compare one result transfer with the oldest expectation
        task check_result(cluster_result_t got);
            cluster_result_t want;
            if (pending.size() == 0)
            begin
                $display("result %0d arrived with none expected", checked);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.action !== want.action) report("action", got.action, want.action);
            if (got.first_label !== want.first_label)
                report("first_label", $signed(got.first_label), $signed(want.first_label));
            if (got.second_label !== want.second_label)
                report("second_label", $signed(got.second_label), $signed(want.second_label));
            if (got.moved_count !== want.moved_count)
                report("moved_count", got.moved_count, want.moved_count);
            if (got.clusters_made !== want.clusters_made)
                report("clusters_made", got.clusters_made, want.clusters_made);
            if (got.particles_assigned !== want.particles_assigned)
                report("particles_assigned", got.particles_assigned, want.particles_assigned);
            checked++;
        endtask
    endclass
endpackage

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import pcl_pkg::*;
    import pcl_tb_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic clk;
    logic rst_n;
    int   cycles;
    bit   hold_out;
    bit   long_hold;

    pcl_in_if  in_ch();
    pcl_out_if out_ch();
    pcl_cfg_if cfg_ch();

    cluster_scoreboard board;

    pair_cluster_labeler_with_images dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result side: sample at the rising edge
    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_result({out_ch.action, out_ch.first_label, out_ch.second_label,
                                out_ch.moved_count, out_ch.clusters_made,
                                out_ch.particles_assigned});

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Receiver stalls: random gaps (none while hold_out is set), or a long hold-off on request
    initial
    begin
        int n;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_ch.ready <= 1'b0;
                repeat (400) @(negedge clk);
                long_hold = 1'b0;
            end
            n = hold_out ? 0 : gap_len();
            if (n > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic send_item(logic [1:0] cmd, int a, int b, logic [7:0] ox,
                             logic [7:0] oy, logic [7:0] oz);
        in_ch.valid <= 1'b1;
        in_ch.command <= cmd;
        in_ch.first_particle <= a[9:0];
        in_ch.second_particle <= b[9:0];
        in_ch.offset_x <= ox;
        in_ch.offset_y <= oy;
        in_ch.offset_z <= oz;
        do @(posedge clk); while (!in_ch.ready);
        board.note_input(cmd, a[9:0], b[9:0], ox, oy, oz);
        @(negedge clk);
    endtask

    task automatic send_gap(int n);
        if (n > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        // extra wait; a clear or merge sweep already ends before its result
        repeat (1100) @(negedge clk);
    endtask

    task automatic write_slots(int value);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value[10:0];
        do @(posedge clk); while (!cfg_ch.ready);
        board.set_slots(value);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic int pick_slot(int span);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4) return $urandom_range(0, 1023);
        if (roll < 8) return span - 1;
        return $urandom_range(0, span - 1);
    endfunction

    task automatic random_item(int span);
        int roll;
        int a;
        int b;
        roll = $urandom_range(0, 99);
        a = pick_slot(span);
        b = pick_slot(span);
        if (roll < 2)
            send_item(CMD_CLEAR, a, b, 8'($urandom), 8'($urandom), 8'($urandom));
        else if (roll < 4)
            send_item(CMD_IGNORED, a, b, 8'($urandom), 8'($urandom), 8'($urandom));
        else if (roll < 15)
            send_item(CMD_CLOSE, a, b, 8'($urandom), 8'($urandom), 8'($urandom));
        else
            send_item(CMD_PAIR, a, b, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    initial
    begin
        int span;
        board = new();
        cycles = 0;
        hold_out = 1'b0;
        long_hold = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_CLEAR;
        in_ch.first_particle = '0;
        in_ch.second_particle = '0;
        in_ch.offset_x = '0;
        in_ch.offset_y = '0;
        in_ch.offset_z = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: small frame, every action and the corner cases
        write_slots(8);
        send_item(CMD_PAIR, 0, 1, 8'h7f, 8'h80, 8'h01);
        send_item(CMD_PAIR, 2, 1, 8'h80, 8'h7f, 8'hff);
        send_item(CMD_PAIR, 1, 3, 8'h00, 8'h05, 8'hfb);
        send_item(CMD_PAIR, 4, 5, 8'h11, 8'h22, 8'h33);
        send_item(CMD_PAIR, 0, 5, 8'hff, 8'h00, 8'h7f);
        send_item(CMD_PAIR, 0, 4, 8'h01, 8'h01, 8'h01);
        send_item(CMD_PAIR, 3, 3, 8'h00, 8'h00, 8'h00);
        send_item(CMD_PAIR, 7, 8, 8'h00, 8'h00, 8'h00);
        send_item(CMD_PAIR, 1023, 6, 8'h55, 8'haa, 8'h00);
        send_item(CMD_CLOSE, 6, 0, 8'h00, 8'h00, 8'h00);
        send_item(CMD_CLOSE, 6, 1023, 8'hff, 8'hff, 8'hff);
        send_item(CMD_CLOSE, 9, 0, 8'h00, 8'h00, 8'h00);
        send_item(CMD_PAIR, 6, 7, 8'h40, 8'hc0, 8'h20);
        send_item(CMD_IGNORED, 1023, 1023, 8'hff, 8'hff, 8'hff);
        send_item(CMD_CLEAR, 0, 0, 8'h00, 8'h00, 8'h00);
        send_item(CMD_PAIR, 0, 7, 8'h03, 8'h02, 8'h01);

        // Full-range setting, with slot 1023 in use
        write_slots(1024);
        send_item(CMD_PAIR, 1023, 512, 8'h80, 8'h80, 8'h80);
        send_item(CMD_PAIR, 0, 1023, 8'h7f, 8'h7f, 8'h7f);
        send_item(CMD_CLEAR, 0, 0, 8'h00, 8'h00, 8'h00);
        // Above the slot count saturates; then a single slot
        write_slots(2047);
        write_slots(1);
        send_item(CMD_CLOSE, 0, 0, 8'h00, 8'h00, 8'h00);
        send_item(CMD_PAIR, 0, 1, 8'h00, 8'h00, 8'h00);

        // Random phases over several frame sizes; most small
        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase % 4)
                0: span = $urandom_range(2, 16);
                1: span = $urandom_range(17, 64);
                2: span = $urandom_range(2, 32);
                default: span = (phase == 11) ? 1024 : $urandom_range(65, 200);
            endcase
            write_slots(span);
            send_item(CMD_CLEAR, 0, 0, 8'h00, 8'h00, 8'h00);
            if (phase == 3)
                long_hold = 1'b1;
            if (phase == 5)
                hold_out = 1'b1;
            else
                hold_out = 1'b0;
            for (int n = 0; n < 100; n++)
            begin
                if (phase % 3 != 1) send_gap(gap_len());
                random_item(span);
            end
            if (phase == 7)
            begin
                // sender waits until every expected result is in
                in_ch.valid <= 1'b0;
                while (board.pending.size() != 0) @(negedge clk);
            end
        end

        drain();
        $display("checked %0d results over %0d merges; actions none/new/joinA/joinB/merge/single:",
                 board.checked, board.merges_seen);
        $display("  %0d %0d %0d %0d %0d %0d", board.actions_seen[0], board.actions_seen[1],
                 board.actions_seen[2], board.actions_seen[3], board.actions_seen[4],
                 board.actions_seen[5]);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

FILE: pair_cluster_labeler_with_images.f
rtl/pcl_pkg.sv
rtl/pcl_ifs.sv
rtl/pcl_ctrl.sv
rtl/pcl_dp.sv
rtl/pair_cluster_labeler_with_images.sv
bench/tb_ifs_note.sv
bench/tb.sv
